// ===== hdl/psie_pkg.sv =====
// Shared types and constants for the prefix set include/exclude unit.
`default_nettype none
package psie_pkg;

    localparam int unsigned NET_W = 64;
    localparam int unsigned LEN_W = 7;
    localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;

    typedef enum logic [1:0] {
        ACT_INCLUDE = 2'd0,
        ACT_EXCLUDE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_CLEAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_READ_WAIT,
        S_READ_DONE,
        S_INC_COVER,
        S_INC_SIB,
        S_INC_CLIMB,
        S_INC_KEEP,
        S_INC_COMPACT,
        S_INC_APPEND,
        S_EXC_FIND,
        S_EXC_SHIFT,
        S_EXC_NEXT,
        S_EXC_DROP,
        S_DONE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;          // capture the item
        logic scan_clear;    // reset scan pointers / accumulators
        logic scan_step;     // advance scan by one entry
        logic cover_test;    // include: test cover, set hit
        logic sib_acc;       // include: accumulate sibling bits
        logic climb_init;    // include: shift scale into position
        logic climb_step;    // include: climb one level
        logic keep_acc;      // include: count kept entries
        logic compact_write; // write kept entry at write pointer
        logic append;        // write base entry, set count
        logic exc_test;      // exclude: test cover of entry
        logic shift_write;   // exclude: move entry down by one
        logic shift_done;    // exclude: decrement count
        logic sib_next;      // exclude: next level
        logic drop_write;    // exclude: compact away inner entries
        logic drop_done;     // exclude: set count to write pointer
        logic set_full;      // record table full
        logic clear_count;   // clear table
        logic read_fetch;    // read request
        logic read_take;     // capture read result
        logic strobe;        // present result
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] action;
        logic       scan_end;    // scan pointer reached count
        logic       hit;         // cover found
        logic       climb_more;  // climb continues
        logic       keep_full;   // kept >= depth
        logic       keep_match;  // current entry is kept
        logic       exc_more;    // more sibling levels
    } dp_stat_t;

    function automatic logic [NET_W-1:0] host_mask(input logic [LEN_W-1:0] len);
        logic [NET_W-1:0] m;
        begin
            if (len >= MAX_LEN)
                m = '0;
            else
                m = {NET_W{1'b1}} >> len;
            return m;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/prefix_set_include_exclude_unit.sv =====
// Top level of the prefix set include/exclude unit.
// Usage: drive action, network, prefix_len and index and raise start while busy is low;
// the item transfers at that edge and busy rises for the whole operation.
// One result per item appears on status, count, entry_network and entry_prefix_len for
// exactly one cycle, marked by done; the receiver cannot stall it.
// A read fetches the entry and then takes it; a clear goes straight to done. An include
// runs up to four scans of the table, each visiting every stored entry (memory read then
// use), plus up to 64 climb steps. An exclude scans once to find a cover, shifts the table,
// then runs one include per level below it (up to 64), or a single drop scan.
// The table memory sets the pace: each entry visit reads memory, then uses the data.
// Reset empties the table; table contents are undefined until written.
// Busy falls with done, so the next item can transfer at the edge that ends done.
`default_nettype none
module prefix_set_include_exclude_unit
#(
    parameter int unsigned TABLE_DEPTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] network,
    input  wire logic [6:0]  prefix_len,
    input  wire logic [9:0]  index,
    output logic             done,
    output logic [1:0]       status,
    output logic [10:0]      count,
    output logic [63:0]      entry_network,
    output logic [6:0]       entry_prefix_len
);

    psie_pkg::dp_cmd_t  cmd;
    psie_pkg::dp_stat_t stat;
    psie_pkg::dp_stat_t stat_c;

    // Action feeds the controller directly at start
    always_comb
    begin
        stat_c = stat;
        if (!busy)
            stat_c.action = action;
    end

    psie_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat_c),
        .cmd   (cmd)
    );

    psie_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .action           (action),
        .network          (network),
        .prefix_len       (prefix_len),
        .index            (index),
        .strobe           (done),
        .status           (status),
        .count            (count),
        .entry_network    (entry_network),
        .entry_prefix_len (entry_prefix_len)
    );

endmodule
`default_nettype wire

// ===== hdl/psie_ctrl.sv =====
// Controller state machine for the prefix set include/exclude unit.
`default_nettype none
module psie_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire psie_pkg::dp_stat_t stat,
    output psie_pkg::dp_cmd_t       cmd
);

    psie_pkg::state_t state_reg, state_next;
    // set when current include is a sibling include under an exclude
    logic in_exc_reg, in_exc_next;
    // memory read phase flag: set once the address is issued, while the data is used
    logic rd_ph_reg, rd_ph_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psie_pkg::S_IDLE;
            in_exc_reg <= 1'b0;
            rd_ph_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            in_exc_reg <= in_exc_next;
            rd_ph_reg <= rd_ph_next;
        end
    end

    assign busy = (state_reg != psie_pkg::S_IDLE);

    // Every scanning state reads memory: phase 0 issues the address, phase 1 uses data
    always_comb
    begin
        state_next = state_reg;
        in_exc_next = in_exc_reg;
        rd_ph_next = 1'b0;
        cmd = '0;
        unique case (state_reg)
            psie_pkg::S_IDLE:
            begin
                in_exc_next = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    cmd.scan_clear = 1'b1;
                    unique case (stat.action)
                        psie_pkg::ACT_INCLUDE: state_next = psie_pkg::S_INC_COVER;
                        psie_pkg::ACT_EXCLUDE: state_next = psie_pkg::S_EXC_FIND;
                        psie_pkg::ACT_READ:    state_next = psie_pkg::S_READ_WAIT;
                        default:
                        begin
                            cmd.clear_count = 1'b1;
                            state_next = psie_pkg::S_DONE;
                        end
                    endcase
                end
            end
            psie_pkg::S_READ_WAIT:
            begin
                cmd.read_fetch = 1'b1;
                state_next = psie_pkg::S_READ_DONE;
            end
            psie_pkg::S_READ_DONE:
            begin
                cmd.read_take = 1'b1;
                state_next = psie_pkg::S_DONE;
            end
            psie_pkg::S_INC_COVER:
            begin
                if (stat.scan_end)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next = psie_pkg::S_INC_SIB;
                end
                else if (!rd_ph_reg)
                    rd_ph_next = 1'b1;
                else if (stat.hit)
                    state_next = in_exc_reg ? psie_pkg::S_EXC_NEXT : psie_pkg::S_DONE;
                else
                begin
                    cmd.cover_test = 1'b1;
                    cmd.scan_step = 1'b1;
                end
            end
            psie_pkg::S_INC_SIB:
            begin
                if (stat.scan_end)
                begin
                    cmd.climb_init = 1'b1;
                    state_next = psie_pkg::S_INC_CLIMB;
                end
                else if (!rd_ph_reg)
                    rd_ph_next = 1'b1;
                else
                begin
                    cmd.sib_acc = 1'b1;
                    cmd.scan_step = 1'b1;
                end
            end
            psie_pkg::S_INC_CLIMB:
            begin
                if (stat.climb_more)
                    cmd.climb_step = 1'b1;
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next = psie_pkg::S_INC_KEEP;
                end
            end
            psie_pkg::S_INC_KEEP:
            begin
                if (stat.scan_end)
                begin
                    cmd.scan_clear = 1'b1;
                    if (stat.keep_full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next = in_exc_reg ? psie_pkg::S_EXC_NEXT : psie_pkg::S_DONE;
                    end
                    else
                        state_next = psie_pkg::S_INC_COMPACT;
                end
                else if (!rd_ph_reg)
                    rd_ph_next = 1'b1;
                else
                begin
                    cmd.keep_acc = 1'b1;
                    cmd.scan_step = 1'b1;
                end
            end
            psie_pkg::S_INC_COMPACT:
            begin
                if (stat.scan_end)
                    state_next = psie_pkg::S_INC_APPEND;
                else if (!rd_ph_reg)
                    rd_ph_next = 1'b1;
                else
                begin
                    cmd.compact_write = stat.keep_match;
                    cmd.scan_step = 1'b1;
                end
            end
            psie_pkg::S_INC_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = in_exc_reg ? psie_pkg::S_EXC_NEXT : psie_pkg::S_DONE;
            end
            psie_pkg::S_EXC_FIND:
            begin
                // a hit switches scan_end to the shift bound, so test it first
                if (stat.hit)
                begin
                    // scan pointer stays at the hit; shift follows from there
                    state_next = psie_pkg::S_EXC_SHIFT;
                end
                else if (stat.scan_end)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next = psie_pkg::S_EXC_DROP;
                end
                else if (!rd_ph_reg)
                    rd_ph_next = 1'b1;
                else
                begin
                    cmd.exc_test = 1'b1;
                    cmd.scan_step = 1'b1;
                end
            end
            psie_pkg::S_EXC_SHIFT:
            begin
                // shift entries above the hit down by one: read i+1, write i
                if (stat.scan_end)
                begin
                    cmd.shift_done = 1'b1;
                    state_next = psie_pkg::S_EXC_NEXT;
                end
                else if (!rd_ph_reg)
                    rd_ph_next = 1'b1;
                else
                begin
                    cmd.shift_write = 1'b1;
                    cmd.scan_step = 1'b1;
                end
            end
            psie_pkg::S_EXC_NEXT:
            begin
                if (stat.exc_more)
                begin
                    cmd.sib_next = 1'b1;
                    cmd.scan_clear = 1'b1;
                    in_exc_next = 1'b1;
                    state_next = psie_pkg::S_INC_COVER;
                end
                else
                    state_next = psie_pkg::S_DONE;
            end
            psie_pkg::S_EXC_DROP:
            begin
                if (stat.scan_end)
                begin
                    cmd.drop_done = 1'b1;
                    state_next = psie_pkg::S_DONE;
                end
                else if (!rd_ph_reg)
                    rd_ph_next = 1'b1;
                else
                begin
                    cmd.drop_write = stat.keep_match;
                    cmd.scan_step = 1'b1;
                end
            end
            psie_pkg::S_DONE:
            begin
                cmd.strobe = 1'b1;
                state_next = psie_pkg::S_IDLE;
            end
            default: state_next = psie_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/psie_dp.sv =====
// Datapath for the prefix set include/exclude unit: table memory, scan and arithmetic.
`default_nettype none
module psie_dp
#(
    parameter int unsigned TABLE_DEPTH = 1024
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire psie_pkg::dp_cmd_t         cmd,
    output psie_pkg::dp_stat_t             stat,
    input  wire logic [1:0]                action,
    input  wire logic [psie_pkg::NET_W-1:0] network,
    input  wire logic [psie_pkg::LEN_W-1:0] prefix_len,
    input  wire logic [9:0]                index,
    output logic                           strobe,
    output logic [1:0]                     status,
    output logic [10:0]                    count,
    output logic [psie_pkg::NET_W-1:0]     entry_network,
    output logic [psie_pkg::LEN_W-1:0]     entry_prefix_len
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned XW = (CW > 10) ? CW : 10;
    localparam int unsigned NW = psie_pkg::NET_W;
    localparam int unsigned LW = psie_pkg::LEN_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // Table memory
    logic [NW-1:0] net_mem [TABLE_DEPTH];
    logic [LW-1:0] len_mem [TABLE_DEPTH];
    logic [NW-1:0] rd_net_reg;
    logic [LW-1:0] rd_len_reg;

    // Item and working registers
    logic [1:0]    act_reg;
    logic [NW-1:0] net_reg;      // exclude: masked network
    logic [LW-1:0] len_reg;      // exclude: excluded length
    logic [9:0]    idx_reg;
    logic [NW-1:0] base_reg;     // include working base
    logic [LW-1:0] ilen_reg;     // include working length
    logic [NW-1:0] scale_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] ptr_reg;      // scan read pointer
    logic [CW-1:0] wptr_reg;     // compaction write pointer
    logic [CW-1:0] kept_reg;
    logic          hit_reg;
    logic          full_reg;
    logic [LW-1:0] klev_reg;     // exclude sibling level
    logic [NW-1:0] res_net_reg;
    logic [LW-1:0] res_len_reg;
    logic          ok_reg;
    logic          strobe_reg;

    logic [LW-1:0] len_clamp;
    logic [CW-1:0] rd_addr;
    logic [NW-1:0] ihm, ibase_m, skm, st, exc_hm;

    assign len_clamp = (prefix_len > psie_pkg::MAX_LEN) ? psie_pkg::MAX_LEN : prefix_len;

    // Read address: the shift reads one entry ahead of the write
    always_comb
    begin
        rd_addr = ptr_reg;
        if (cmd.read_fetch)
            rd_addr = CW'(idx_reg);
    end

    logic [CW-1:0] shift_rd;
    assign shift_rd = ptr_reg + CW'(1);

    // Memory: one write and one registered read a cycle
    logic [CW-1:0] rd_sel;
    logic          shift_mode_reg;
    assign rd_sel = shift_mode_reg ? shift_rd : rd_addr;

    always_ff @(posedge clk)
    begin
        if (rd_sel < DEPTH_C)
        begin
            rd_net_reg <= net_mem[rd_sel[AW-1:0]];
            rd_len_reg <= len_mem[rd_sel[AW-1:0]];
        end
        if (cmd.compact_write || cmd.drop_write)
        begin
            net_mem[wptr_reg[AW-1:0]] <= rd_net_reg;
            len_mem[wptr_reg[AW-1:0]] <= rd_len_reg;
        end
        else if (cmd.shift_write)
        begin
            net_mem[ptr_reg[AW-1:0]] <= rd_net_reg;
            len_mem[ptr_reg[AW-1:0]] <= rd_len_reg;
        end
        else if (cmd.append)
        begin
            net_mem[wptr_reg[AW-1:0]] <= base_reg;
            len_mem[wptr_reg[AW-1:0]] <= ilen_reg;
        end
    end

    // Combinational tests on the entry just read
    logic [CW-1:0] shift_end;
    assign ihm = psie_pkg::host_mask(ilen_reg);
    assign ibase_m = base_reg & ~ihm;
    assign skm = psie_pkg::host_mask(rd_len_reg);
    assign st = rd_net_reg ^ (base_reg & ~skm);
    assign exc_hm = psie_pkg::host_mask(len_reg);
    assign shift_end = cnt_reg - CW'(1);

    logic cover_hit, exc_hit, keep_m, drop_m;
    assign cover_hit = (rd_len_reg <= ilen_reg) && (rd_net_reg == (base_reg & ~skm));
    assign exc_hit = (rd_len_reg <= len_reg) && (rd_net_reg == (net_reg & ~skm));
    assign keep_m = ((rd_net_reg & ~ihm) != ibase_m);
    assign drop_m = !((rd_len_reg > len_reg) && ((rd_net_reg & ~exc_hm) == net_reg));

    always_comb
    begin
        stat = '0;
        stat.action = act_reg;
        stat.scan_end = shift_mode_reg ? (ptr_reg >= shift_end) : (ptr_reg >= cnt_reg);
        stat.hit = hit_reg;
        stat.climb_more = (ilen_reg != '0) && scale_reg[0];
        stat.keep_full = (kept_reg >= DEPTH_C);
        stat.keep_match = (act_reg == psie_pkg::ACT_EXCLUDE && !shift_mode_reg && klev_reg == '0)
                          ? drop_m : keep_m;
        stat.exc_more = (klev_reg < len_reg);
    end

    // Working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            strobe_reg <= 1'b0;
            shift_mode_reg <= 1'b0;
            act_reg <= '0;
            ptr_reg <= '0;
            wptr_reg <= '0;
            klev_reg <= '0;
            hit_reg <= 1'b0;
            full_reg <= 1'b0;
            idx_reg <= '0;
            len_reg <= '0;
            net_reg <= '0;
            base_reg <= '0;
            ilen_reg <= '0;
            scale_reg <= '0;
            kept_reg <= '0;
            res_net_reg <= '0;
            res_len_reg <= '0;
            ok_reg <= 1'b1;
        end
        else
        begin
            strobe_reg <= cmd.strobe;
            if (cmd.load)
            begin
                act_reg <= action;
                idx_reg <= index;
                len_reg <= len_clamp;
                net_reg <= network & ~psie_pkg::host_mask(len_clamp);
                base_reg <= network & ~psie_pkg::host_mask(len_clamp);
                ilen_reg <= len_clamp;
                full_reg <= 1'b0;
                klev_reg <= '0;
                shift_mode_reg <= 1'b0;
                res_net_reg <= '0;
                res_len_reg <= '0;
                ok_reg <= 1'b1;
            end
            if (cmd.scan_clear)
            begin
                ptr_reg <= '0;
                wptr_reg <= '0;
                kept_reg <= '0;
                hit_reg <= 1'b0;
                scale_reg <= '0;
            end
            if (cmd.cover_test && cover_hit)
                hit_reg <= 1'b1;
            if (cmd.exc_test && exc_hit)
            begin
                hit_reg <= 1'b1;
                klev_reg <= rd_len_reg;
                shift_mode_reg <= 1'b1;
            end
            if (cmd.scan_step && !(cmd.exc_test && exc_hit) && !(cmd.cover_test && cover_hit))
                ptr_reg <= ptr_reg + CW'(1);
            if (cmd.sib_acc && rd_len_reg <= ilen_reg && st == skm + NW'(1))
                scale_reg <= scale_reg | st;
            if (cmd.climb_init)
            begin
                if (ilen_reg == '0)
                    scale_reg <= '0;
                else
                    scale_reg <= scale_reg >> (NW'(psie_pkg::MAX_LEN) - NW'(ilen_reg));
            end
            if (cmd.climb_step)
            begin
                ilen_reg <= ilen_reg - LW'(1);
                scale_reg <= scale_reg >> 1;
            end
            if (cmd.climb_step == 1'b0 && cmd.scan_clear && !cmd.load && !cmd.sib_next)
                base_reg <= ibase_m;
            if (cmd.keep_acc && keep_m)
                kept_reg <= kept_reg + CW'(1);
            if (cmd.compact_write || cmd.drop_write)
                wptr_reg <= wptr_reg + CW'(1);
            if (cmd.append)
            begin
                cnt_reg <= wptr_reg + CW'(1);
            end
            if (cmd.shift_done)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                shift_mode_reg <= 1'b0;
            end
            if (cmd.sib_next)
            begin
                klev_reg <= klev_reg + LW'(1);
                ilen_reg <= klev_reg + LW'(1);
                base_reg <= (net_reg & ~psie_pkg::host_mask(klev_reg + LW'(1)))
                            ^ (psie_pkg::host_mask(klev_reg + LW'(1)) + NW'(1));
            end
            if (cmd.drop_done)
                cnt_reg <= wptr_reg;
            if (cmd.set_full)
                full_reg <= 1'b1;
            if (cmd.clear_count)
                cnt_reg <= '0;
            if (cmd.read_take)
            begin
                if (XW'(idx_reg) < XW'(cnt_reg))
                begin
                    res_net_reg <= rd_net_reg;
                    res_len_reg <= rd_len_reg;
                end
                else
                    ok_reg <= 1'b0;
            end
        end
    end

    // Result
    assign strobe = strobe_reg;
    always_comb
    begin
        if (act_reg == psie_pkg::ACT_READ && !ok_reg)
            status = psie_pkg::ST_BAD_INDEX;
        else if (full_reg)
            status = psie_pkg::ST_FULL;
        else
            status = psie_pkg::ST_OK;
    end
    assign count = 11'(cnt_reg);
    assign entry_network = res_net_reg;
    assign entry_prefix_len = res_len_reg;

endmodule
`default_nettype wire

// ===== tb/prefix_set_checker.sv =====
// Checker for the prefix set unit: predicts each result and compares it with the block.
`default_nettype none
module prefix_set_checker
#(
    parameter int unsigned DEPTH = 1024
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [1:0]  action,
    input  wire logic [63:0] network,
    input  wire logic [6:0]  prefix_len,
    input  wire logic [9:0]  index,
    input  wire logic        done,
    input  wire logic [1:0]  status,
    input  wire logic [10:0] count,
    input  wire logic [63:0] entry_network,
    input  wire logic [6:0]  entry_prefix_len,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        psie_pkg::status_t st;
        logic [10:0]       cnt;
        logic [63:0]       net;
        logic [6:0]        len;
    } outcome_t;

    // Shadow copy of the prefix table
    logic [63:0] tbl_net [DEPTH];
    logic [6:0]  tbl_len [DEPTH];
    int unsigned tbl_cnt;
    outcome_t    awaited [$];
    int          mismatches;

    function automatic logic [63:0] hmask(int unsigned l);
        return (l >= 64) ? 64'd0 : ({64{1'b1}} >> l);
    endfunction

    // Include one prefix; returns 1 when the table is full
    function automatic bit include_prefix(logic [63:0] n, int unsigned l);
        logic [63:0] base, scale, km, t, hm;
        int unsigned kept, j, sl;
        scale = '0;
        for (int unsigned i = 0; i < tbl_cnt; i++)
        begin
            sl = 32'(tbl_len[i]);
            if (sl <= l && tbl_net[i] == (n & ~hmask(sl)))
                return 0;
        end
        base = n & ~hmask(l);
        for (int unsigned i = 0; i < tbl_cnt; i++)
        begin
            sl = 32'(tbl_len[i]);
            if (sl > l)
                continue;
            km = hmask(sl);
            t = tbl_net[i] ^ (base & ~km);
            if (t == km + 64'd1)
                scale |= t;
        end
        if (l == 0)
            scale = '0;
        else
            scale = scale >> (64 - l);
        while (l > 0 && scale[0])
        begin
            l--;
            scale = scale >> 1;
        end
        hm = hmask(l);
        base &= ~hm;
        kept = 0;
        for (int unsigned i = 0; i < tbl_cnt; i++)
            if ((tbl_net[i] & ~hm) != base)
                kept++;
        if (kept >= DEPTH)
            return 1;
        j = 0;
        for (int unsigned i = 0; i < tbl_cnt; i++)
            if ((tbl_net[i] & ~hm) != base)
            begin
                tbl_net[j] = tbl_net[i];
                tbl_len[j] = tbl_len[i];
                j++;
            end
        tbl_net[j] = base;
        tbl_len[j] = l[6:0];
        tbl_cnt = j + 1;
        return 0;
    endfunction

    // Exclude one prefix; returns 1 if a sibling include found the table full
    function automatic bit exclude_prefix(logic [63:0] n, int unsigned l);
        logic [63:0] em, m;
        int unsigned p, j;
        bit full;
        full = 0;
        em = hmask(l);
        n &= ~em;
        for (int unsigned i = 0; i < tbl_cnt; i++)
        begin
            p = 32'(tbl_len[i]);
            if (p <= l && tbl_net[i] == (n & ~hmask(p)))
            begin
                for (j = i + 1; j < tbl_cnt; j++)
                begin
                    tbl_net[j-1] = tbl_net[j];
                    tbl_len[j-1] = tbl_len[j];
                end
                tbl_cnt--;
                for (int unsigned k = p + 1; k <= l; k++)
                begin
                    m = hmask(k);
                    if (include_prefix((n & ~m) ^ (m + 64'd1), k))
                        full = 1;
                end
                return full;
            end
        end
        j = 0;
        for (int unsigned i = 0; i < tbl_cnt; i++)
        begin
            if (32'(tbl_len[i]) > l && (tbl_net[i] & ~em) == n)
                continue;
            tbl_net[j] = tbl_net[i];
            tbl_len[j] = tbl_len[i];
            j++;
        end
        tbl_cnt = j;
        return 0;
    endfunction

    function automatic outcome_t predict_outcome(psie_pkg::action_t act, logic [63:0] n,
                                                 logic [6:0] pl, logic [9:0] idx);
        outcome_t o;
        int unsigned l;
        o = '0;
        o.st = psie_pkg::ST_OK;
        l = (pl > psie_pkg::MAX_LEN) ? 32'd64 : 32'(pl);
        unique case (act)
            psie_pkg::ACT_INCLUDE: if (include_prefix(n, l)) o.st = psie_pkg::ST_FULL;
            psie_pkg::ACT_EXCLUDE: if (exclude_prefix(n, l)) o.st = psie_pkg::ST_FULL;
            psie_pkg::ACT_READ:
                if (32'(idx) < tbl_cnt && 32'(idx) < DEPTH)
                begin
                    o.net = tbl_net[idx];
                    o.len = tbl_len[idx];
                end
                else
                    o.st = psie_pkg::ST_BAD_INDEX;
            default: tbl_cnt = 0;
        endcase
        o.cnt = tbl_cnt[10:0];
        return o;
    endfunction

    // Predict on each command transfer, compare on each strobe
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t exp_o;
        if (!rst_n)
        begin
            tbl_cnt = 0;
            awaited.delete();
            fail_count = 0;
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (awaited.size() == 0)
                begin
                    fail_count++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with nothing awaited, status %0d", status);
                end
                else
                begin
                    exp_o = awaited.pop_front();
                    if (status !== exp_o.st || count !== exp_o.cnt ||
                        entry_network !== exp_o.net || entry_prefix_len !== exp_o.len)
                    begin
                        fail_count++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp st %0d cnt %0d net %h len %0d, got %0d %0d %h %0d",
                                     exp_o.st, exp_o.cnt, exp_o.net, exp_o.len,
                                     status, count, entry_network, entry_prefix_len);
                    end
                end
            end
            if (start && !busy)
                awaited.push_back(predict_outcome(psie_pkg::action_t'(action), network,
                                                  prefix_len, index));
            pending = awaited.size();
        end
    end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Top of the prefix set unit testbench: clock, reset, stimulus and verdict.
`default_nettype none
module testbench;

    localparam int unsigned DEPTH = 1024;
    // cycles allowed without any transfer or result
    localparam int CYCLE_LIMIT = 4000000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [63:0] network;
    logic [6:0]  prefix_len;
    logic [9:0]  index;
    logic        done;
    logic [1:0]  status;
    logic [10:0] count;
    logic [63:0] entry_network;
    logic [6:0]  entry_prefix_len;
    int          fail_count;
    int          pending;
    int          cycles;
    int          n_transfers;
    int          n_tracked;
    logic [63:0] recent_net [8];
    logic [6:0]  recent_len [8];

    prefix_set_include_exclude_unit #(.TABLE_DEPTH(DEPTH)) dut (.*);

    prefix_set_checker #(.DEPTH(DEPTH)) checker_i (.*);

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Watchdog: restarts on every transfer and every result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            cycles <= 0;
        else
            cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL prefix_set_include_exclude_unit");
            $finish;
        end
    end

    // One command transfer, then an optional gap
    task automatic send_cmd(psie_pkg::action_t act, logic [63:0] n, logic [6:0] pl,
                            logic [9:0] idx);
        int gap;
        action     <= act;
        network    <= n;
        prefix_len <= pl;
        index      <= idx;
        start      <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        n_transfers++;
        @(negedge clk);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
              ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
        if (gap != 0)
        begin
            start  <= 1'b0;
            action <= psie_pkg::action_t'($urandom_range(0, 3));
            network <= {$urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random prefix, mostly near a small cluster so that merges and covers happen
    task automatic rand_prefix(output logic [63:0] n, output logic [6:0] pl);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
        begin
            pl = 7'($urandom_range(1, 8) + ($urandom_range(0, 1) ? 56 : 0));
            n = {$urandom, $urandom};
            if (pl > 8)
                n[63:56] = 8'hA5;
            n[63:60] = ($urandom_range(0, 3) == 0) ? n[63:60] : 4'hA;
        end
        else if (r < 8)
        begin
            n = recent_net[$urandom_range(0, 7)] ^ (64'd1 << $urandom_range(0, 63));
            pl = recent_len[$urandom_range(0, 7)];
        end
        else
        begin
            n = {$urandom, $urandom};
            pl = 7'($urandom_range(0, 127));
        end
        recent_net[n_tracked % 8] = n;
        recent_len[n_tracked % 8] = pl;
        n_tracked++;
    endtask

    initial
    begin
        logic [63:0] n;
        logic [6:0]  pl;
        int          r;
        rst_n = 1'b0;
        start = 1'b0;
        action = psie_pkg::ACT_INCLUDE;
        network = '0;
        prefix_len = '0;
        index = '0;
        n_transfers = 0;
        n_tracked = 0;
        for (int i = 0; i < 8; i++)
        begin
            recent_net[i] = 64'hA000_0000_0000_0000;
            recent_len[i] = 7'd8;
        end
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: reads of an empty table, extremes, merges, covers, excludes
        send_cmd(psie_pkg::ACT_READ, '0, '0, 10'd0);
        send_cmd(psie_pkg::ACT_READ, '1, 7'h7F, 10'h3FF);
        send_cmd(psie_pkg::ACT_INCLUDE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, '0);
        send_cmd(psie_pkg::ACT_INCLUDE, 64'hFFFF_FFFF_FFFF_FFFE, 7'h7F, '0);   // sibling merges up
        send_cmd(psie_pkg::ACT_INCLUDE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64, '0);   // already covered
        send_cmd(psie_pkg::ACT_READ, '0, '0, 10'd0);
        send_cmd(psie_pkg::ACT_INCLUDE, 64'h0A00_0000_0000_0000, 7'd8, '0);
        send_cmd(psie_pkg::ACT_INCLUDE, 64'h0B00_0000_0000_0000, 7'd8, '0);
        send_cmd(psie_pkg::ACT_READ, '0, '0, 10'd1);
        send_cmd(psie_pkg::ACT_EXCLUDE, 64'h0A12_3456_789A_BCDE, 7'd24, '0);   // split a cover
        send_cmd(psie_pkg::ACT_READ, '0, '0, 10'd5);
        send_cmd(psie_pkg::ACT_EXCLUDE, 64'hFFFF_FFFF_FFFF_FFFF, 7'd1, '0);    // drop inner entries
        send_cmd(psie_pkg::ACT_EXCLUDE, 64'h1234_0000_0000_0000, 7'd16, '0);   // nothing there
        send_cmd(psie_pkg::ACT_INCLUDE, 64'h5555_5555_5555_5555, 7'd0, '0);    // whole space
        send_cmd(psie_pkg::ACT_READ, '0, '0, 10'd0);
        send_cmd(psie_pkg::ACT_EXCLUDE, 64'h8000_0000_0000_0001, 7'd64, '0);   // 64 sibling includes
        send_cmd(psie_pkg::ACT_READ, '0, '0, 10'd63);
        send_cmd(psie_pkg::ACT_READ, '0, '0, 10'd64);
        send_cmd(psie_pkg::ACT_EXCLUDE, '0, 7'd0, '0);
        send_cmd(psie_pkg::ACT_INCLUDE, 64'h1234_0000_0000_0000, 7'd16, '0);
        send_cmd(psie_pkg::ACT_CLEAR, '1, 7'h7F, 10'h3FF);
        send_cmd(psie_pkg::ACT_READ, '0, '0, 10'd0);
        drain();   // let the table settle before random traffic

        // Random: mostly clustered includes and excludes, with reads and the odd clear
        for (int i = 0; i < 120; i++)
        begin
            rand_prefix(n, pl);
            r = $urandom_range(0, 99);
            if (r < 50)
                send_cmd(psie_pkg::ACT_INCLUDE, n, pl, 10'($urandom));
            else if (r < 72)
                send_cmd(psie_pkg::ACT_EXCLUDE, n, pl, 10'($urandom));
            else if (r < 97)
                send_cmd(psie_pkg::ACT_READ, n, pl,
                         ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                                     : 10'($urandom_range(0, 40)));
            else
                send_cmd(psie_pkg::ACT_CLEAR, n, pl, 10'($urandom));
            if (i == 60)
                drain();
        end

        drain();
        repeat (200) @(negedge clk);
        $display("Covered %0d transfers: includes with merges and covers, excludes", n_transfers);
        $display("with splits and drops, reads in and out of range, and clears.");
        if (fail_count == 0 && pending == 0)
            $display("PASS prefix_set_include_exclude_unit");
        else
            $display("FAIL prefix_set_include_exclude_unit");
        $finish;
    end

endmodule
`default_nettype wire
